// File: sv/assert_macros.svh
// Assertion macros shared by the rasterizer RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/tpbs_pkg.sv
// Constants shared by the triangle coverage and shading pipeline.
// No dependencies.
package tpbs_pkg;
	localparam int CHAN_W    = 8;
	localparam int DIV_STEPS = 8;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_V0_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_V0_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_V1_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_V1_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_V2_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_V2_Y = 3'd5;
endpackage

// File: sv/triangle_pixel_barycentric_shade_top.sv
// Triangle coverage and barycentric shading, one pixel per clock.
// A pixel passes the edge stages, the magnitude/saturate stages and the divider
// stages, in that order, from accept to result. Throughput: one item per
// cycle; a stalled result freezes the whole pipeline. arst_n clears the
// vertex registers to 0 and all valid bits.
module triangle_pixel_barycentric_shade_top #(
	parameter int COORD_WIDTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [COORD_WIDTH-1:0]            cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic [COORD_WIDTH-1:0]            pixel_x,
	input  logic [COORD_WIDTH-1:0]            pixel_y,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic                              inside_res,
	output logic                              degenerate,
	output logic [tpbs_pkg::CHAN_W-1:0]       red,
	output logic [tpbs_pkg::CHAN_W-1:0]       green,
	output logic [tpbs_pkg::CHAN_W-1:0]       blue
);
	import tpbs_pkg::*;
	`include "assert_macros.svh"

	localparam int CW  = COORD_WIDTH;
	localparam int EW  = 2*CW+3;
	localparam int MW  = EW-1;
	localparam int NW  = MW+CHAN_W;
	localparam int LAT = 4 + DIV_STEPS;

	logic [CW-1:0] vx_q [0:2];
	logic [CW-1:0] vy_q [0:2];
	logic          en;
	logic [LAT:1]  vld_s;
	logic [LAT:3]  insd_s;
	logic [LAT:3]  degn_s;

	logic signed [EW-1:0] ep [0:2];
	logic signed [EW-1:0] ev [0:2];
	logic [NW-1:0]        num_s3 [0:2];
	logic [MW-1:0]        den_s3 [0:2];
	logic [NW-1:0]        num_s4 [0:2];
	logic [MW-1:0]        den_s4 [0:2];
	logic                 sat_s4 [0:2];
	logic                 zero_s4[0:2];
	logic [CHAN_W-1:0]    quo    [0:2];
	logic [2:0]           outside;

	assign cfg_ready = 1'b1;
	assign pix_stall = res_valid && res_stall;
	assign en        = !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				vx_q[k] <= '0;
				vy_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_V0_X: vx_q[0] <= cfg_data;
				REG_V0_Y: vy_q[0] <= cfg_data;
				REG_V1_X: vx_q[1] <= cfg_data;
				REG_V1_Y: vy_q[1] <= cfg_data;
				REG_V2_X: vx_q[2] <= cfg_data;
				REG_V2_Y: vy_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], pix_valid};
		end
	end

	// edge k runs through the two vertices other than vertex k
	tpbs_edge #(.CW(CW)) u_edge0 (.clk, .en, .ax(vx_q[1]), .ay(vy_q[1]),
		.bx(vx_q[2]), .by(vy_q[2]), .kx(vx_q[0]), .ky(vy_q[0]),
		.px(pixel_x), .py(pixel_y), .ep(ep[0]), .ev(ev[0]));
	tpbs_edge #(.CW(CW)) u_edge1 (.clk, .en, .ax(vx_q[0]), .ay(vy_q[0]),
		.bx(vx_q[2]), .by(vy_q[2]), .kx(vx_q[1]), .ky(vy_q[1]),
		.px(pixel_x), .py(pixel_y), .ep(ep[1]), .ev(ev[1]));
	tpbs_edge #(.CW(CW)) u_edge2 (.clk, .en, .ax(vx_q[1]), .ay(vy_q[1]),
		.bx(vx_q[0]), .by(vy_q[0]), .kx(vx_q[2]), .ky(vy_q[2]),
		.px(pixel_x), .py(pixel_y), .ep(ep[2]), .ev(ev[2]));

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic [MW-1:0] pm, dm;
		assign pm = ep[k][EW-1] ? MW'(-ep[k]) : MW'(ep[k]);
		assign dm = ev[k][EW-1] ? MW'(-ev[k]) : MW'(ev[k]);
		assign outside[k] = (ep[k] > 0 && ev[k] < 0) || (ep[k] < 0 && ev[k] > 0);
		always_ff @(posedge clk) begin
			if (en) begin
				// times 255 as shift minus one
				num_s3[k]  <= (NW'(pm) << CHAN_W) - NW'(pm);
				den_s3[k]  <= dm;
				num_s4[k]  <= num_s3[k];
				den_s4[k]  <= den_s3[k];
				sat_s4[k]  <= num_s3[k] >= (NW'(den_s3[k]) << CHAN_W);
				zero_s4[k] <= den_s3[k] == '0;
			end
		end
		tpbs_div #(.NW(NW), .DW(MW)) u_div (.clk, .en, .num(num_s4[k]),
			.den(den_s4[k]), .sat(sat_s4[k]), .zero(zero_s4[k]), .quo(quo[k]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			insd_s <= {insd_s[LAT-1:3], ~|outside};
			degn_s <= {degn_s[LAT-1:3], ev[0] == '0 || ev[1] == '0 || ev[2] == '0};
		end
	end

	assign res_valid  = vld_s[LAT];
	assign inside_res = insd_s[LAT];
	assign degenerate = degn_s[LAT];
	assign red        = insd_s[LAT] ? quo[0] : '0;
	assign green      = insd_s[LAT] ? quo[1] : '0;
	assign blue       = insd_s[LAT] ? quo[2] : '0;

	`ASSERT_NEXT(a_enter, clk, arst_n, pix_valid && !pix_stall, vld_s[1])
	`ASSERT_IMPLY(a_out_zero, clk, arst_n, res_valid && !inside_res, red == '0 && green == '0 && blue == '0)
	`ASSERT_NEXT(a_hold, clk, arst_n, pix_stall, $stable(vld_s))
endmodule

// File: sv/tpbs_edge.sv
// Two-stage edge function: E(p) and E(k) for the line through a and b.
// Uses no package items.
module tpbs_edge #(
	parameter int CW = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [CW-1:0]         ax,
	input  logic [CW-1:0]         ay,
	input  logic [CW-1:0]         bx,
	input  logic [CW-1:0]         by,
	input  logic [CW-1:0]         kx,
	input  logic [CW-1:0]         ky,
	input  logic [CW-1:0]         px,
	input  logic [CW-1:0]         py,
	output logic signed [2*CW+2:0] ep,
	output logic signed [2*CW+2:0] ev
);
	localparam int EW = 2*CW+3;
	logic signed [EW-1:0] ax_w, ay_w, bx_w, by_w, kx_w, ky_w, px_w, py_w, ea, eb;
	logic signed [EW-1:0] pa_s1, pb_s1, ka_s1, kb_s1, c_s1, ep_s2, ev_s2;

	always_comb begin
		ax_w = EW'($signed({1'b0, ax}));
		ay_w = EW'($signed({1'b0, ay}));
		bx_w = EW'($signed({1'b0, bx}));
		by_w = EW'($signed({1'b0, by}));
		kx_w = EW'($signed({1'b0, kx}));
		ky_w = EW'($signed({1'b0, ky}));
		px_w = EW'($signed({1'b0, px}));
		py_w = EW'($signed({1'b0, py}));
		ea = ay_w - by_w;
		eb = bx_w - ax_w;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= ea * px_w;
			pb_s1 <= eb * py_w;
			ka_s1 <= ea * kx_w;
			kb_s1 <= eb * ky_w;
			c_s1  <= ax_w * by_w - bx_w * ay_w;
			ep_s2 <= pa_s1 + pb_s1 + c_s1;
			ev_s2 <= ka_s1 + kb_s1 + c_s1;
		end
	end

	assign ep = ep_s2;
	assign ev = ev_s2;
endmodule

// File: sv/tpbs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturate
// and force-zero overrides. Depends on tpbs_pkg.
module tpbs_div #(
	parameter int NW = 26,
	parameter int DW = 18
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [NW-1:0]              num,
	input  logic [DW-1:0]              den,
	input  logic                       sat,
	input  logic                       zero,
	output logic [tpbs_pkg::CHAN_W-1:0] quo
);
	import tpbs_pkg::*;
	logic [NW-1:0]     rem_s [0:DIV_STEPS];
	logic [DW-1:0]     den_s [0:DIV_STEPS];
	logic [CHAN_W-1:0] q_s   [0:DIV_STEPS];
	logic              sat_s [0:DIV_STEPS];
	logic              zero_s[0:DIV_STEPS];

	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign q_s[0]    = '0;
	assign sat_s[0]  = sat;
	assign zero_s[0] = zero;

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_step
		logic [NW-1:0] shd;
		logic          ge;
		assign shd = NW'(den_s[i-1]) << (DIV_STEPS - i);
		assign ge  = rem_s[i-1] >= shd;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? rem_s[i-1] - shd : rem_s[i-1];
				q_s[i]    <= q_s[i-1] | (ge ? CHAN_W'(1) << (DIV_STEPS - i) : '0);
				den_s[i]  <= den_s[i-1];
				sat_s[i]  <= sat_s[i-1];
				zero_s[i] <= zero_s[i-1];
			end
		end
	end

	assign quo = zero_s[DIV_STEPS] ? '0 : (sat_s[DIV_STEPS] ? '1 : q_s[DIV_STEPS]);
endmodule
